// ===== design/wcn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcn_pkg
// Types, constants and helpers shared by the 3D Worley F1 noise datapath.
// ----------------------------------------------------------------------------
package wcn_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_W     = 32;
	localparam int INT_W       = COORD_W - FRAC_BITS;
	localparam int HASH_W      = 32;
	localparam int QUOT_W      = FRAC_BITS + 1;
	localparam int ERR_W       = FRAC_BITS + 3;
	localparam int ESQ_W       = 2 * FRAC_BITS + 4;
	localparam int D2_W        = ESQ_W + 2;
	localparam int ROOT_W      = D2_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int DIST_W      = 19;
	localparam int NUM_AXES    = 3;
	localparam int NUM_CELLS   = 27;
	localparam int CELL_STAGES = 7;
	localparam int SQRT_STEPS  = ROOT_W;
	localparam int PIPE_DEPTH  = 1 + CELL_STAGES + (NUM_CELLS - 1) + SQRT_STEPS + 1;

	localparam logic [HASH_W-1:0] MUL_Y     = 32'd57;
	localparam logic [HASH_W-1:0] MUL_Z     = 32'd131;
	localparam logic [HASH_W-1:0] MUL_SEED  = 32'd1337;
	localparam logic [HASH_W-1:0] HASH_MUL  = 32'd15731;
	localparam logic [HASH_W-1:0] HASH_ADD  = 32'd789221;
	localparam logic [HASH_W-1:0] HASH_OFS  = 32'd1376312589;
	localparam logic [HASH_W-1:0] HASH_MASK = 32'h7fffffff;

	localparam logic [DIST_W-1:0] SAT_LIMIT = DIST_W'(6 << FRAC_BITS);
	localparam logic [D2_W-1:0]   D2_MAX    = '1;

	localparam logic [2:0] ADDR_NOISE_SEED = 3'd0;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic [HASH_W-1:0]                  n0;
		logic [NUM_AXES-1:0][FRAC_BITS-1:0] frac;
	} item_t;

	// Hash input offset for one neighbor cell and one feature axis.
	function automatic logic [HASH_W-1:0] hash_key(input logic [1:0] ox,
		input logic [1:0] oy, input logic [1:0] oz, input axis_t axis);
		int dx;
		int dy;
		int dz;
		int k;
		dx = int'(ox) - 1;
		dy = int'(oy) - 1;
		dz = int'(oz) - 1;
		case (axis)
			AXIS_X:  k = dx + 57 * dy + 131 * dz;
			AXIS_Y:  k = (dx + 23) + 57 * (dy - 105) + 131 * (dz + 401);
			AXIS_Z:  k = (dx - 11) + 57 * (dy + 333) + 131 * (dz - 99);
			default: k = 0;
		endcase
		return HASH_W'(k);
	endfunction

endpackage
`default_nettype wire

// ===== design/wcn_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcn_cell
// One neighbor cell: hashes its feature point, squares the distance and
// folds it into the running minimum passed down the chain.
// ----------------------------------------------------------------------------
module wcn_cell import wcn_pkg::*; (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [1:0]      ox,
	input  wire logic [1:0]      oy,
	input  wire logic [1:0]      oz,
	input  wire item_t           item_in,
	output item_t                item_out,
	input  wire logic [D2_W-1:0] best_in,
	output logic [D2_W-1:0]      best_out
);

	item_t                               item_q;
	logic [HASH_W-1:0]                   mix     [NUM_AXES];
	logic [HASH_W-1:0]                   nn_s1   [NUM_AXES];
	logic [HASH_W-1:0]                   nn_s2   [NUM_AXES];
	logic [HASH_W-1:0]                   nn_s3   [NUM_AXES];
	logic [HASH_W-1:0]                   sq_s2   [NUM_AXES];
	logic [HASH_W-1:0]                   t_s3    [NUM_AXES];
	logic [HASH_W-1:0]                   h_s4    [NUM_AXES];
	logic [NUM_AXES-1:0][FRAC_BITS-1:0]  frac_s1, frac_s2, frac_s3, frac_s4;
	logic [ERR_W-1:0]                    e_s5    [NUM_AXES];
	logic signed [2*ERR_W-1:0]           prod    [NUM_AXES];
	logic [ESQ_W-1:0]                    esq_s6  [NUM_AXES];
	logic [1:0]                          ofs     [NUM_AXES];
	logic [D2_W-1:0]                     d2;
	logic [D2_W-1:0]                     best_q;

	assign ofs[0] = ox;
	assign ofs[1] = oy;
	assign ofs[2] = oz;

	always_comb begin
		logic [HASH_W-1:0] n;
		for (int a = 0; a < NUM_AXES; a++) begin
			n      = item_in.n0 + hash_key(ox, oy, oz, axis_t'(a));
			mix[a] = (n << 13) ^ n;
		end
	end

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			prod[a] = $signed(e_s5[a]) * $signed(e_s5[a]);
		end
		d2 = D2_W'(esq_s6[0]) + D2_W'(esq_s6[1]) + D2_W'(esq_s6[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q  <= item_in;
			frac_s1 <= item_in.frac;
			frac_s2 <= frac_s1;
			frac_s3 <= frac_s2;
			frac_s4 <= frac_s3;
			for (int a = 0; a < NUM_AXES; a++) begin
				nn_s1[a]  <= mix[a];
				sq_s2[a]  <= nn_s1[a] * nn_s1[a];
				nn_s2[a]  <= nn_s1[a];
				t_s3[a]   <= sq_s2[a] * HASH_MUL + HASH_ADD;
				nn_s3[a]  <= nn_s2[a];
				h_s4[a]   <= (nn_s3[a] * t_s3[a] + HASH_OFS) & HASH_MASK;
				e_s5[a]   <= ERR_W'(frac_s4[a]) + ERR_W'(h_s4[a][30 -: QUOT_W])
					- ERR_W'({ofs[a], {FRAC_BITS{1'b0}}});
				esq_s6[a] <= prod[a][ESQ_W-1:0];
			end
			best_q <= (d2 < best_in) ? d2 : best_in;
		end
	end

	assign item_out = item_q;
	assign best_out = best_q;

endmodule
`default_nettype wire

// ===== design/wcn_sqrt_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcn_sqrt_step
// One digit of a truncating square root: takes two radicand bits per step.
// ----------------------------------------------------------------------------
module wcn_sqrt_step import wcn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [D2_W-1:0]   v_in,
	input  wire logic [REM_W-1:0]  rem_in,
	input  wire logic [ROOT_W-1:0] root_in,
	output logic [D2_W-1:0]        v_out,
	output logic [REM_W-1:0]       rem_out,
	output logic [ROOT_W-1:0]      root_out
);

	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic              take;
	logic [D2_W-1:0]   v_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	assign rem_sh = {rem_in, v_in[D2_W-1 -: 2]};
	assign trial  = (REM_W+2)'({root_in, 2'b01});
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			v_q    <= {v_in[D2_W-3:0], 2'b00};
			rem_q  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_in[ROOT_W-2:0], take};
		end
	end

	assign v_out    = v_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule
`default_nettype wire

// ===== design/worley_cell_noise_3d.sv =====
`default_nettype none
// Pipeline from input transfer to the earliest result transfer: entry
//   register, seven stages in the first cell and one more per further cell,
//   19 square-root steps, output register.
// Throughput: one item per cycle; the whole pipeline stalls only while a
//   result waits at the output.
// Reset: clears valid bits and noise_seed; datapath registers are not reset.
// ----------------------------------------------------------------------------
// worley_cell_noise_3d
// 3D F1 Worley noise: nearest feature-point distance for a Q16.16 point.
// ----------------------------------------------------------------------------
module worley_cell_noise_3d import wcn_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [DIST_W-1:0]       nearest_distance
);

	logic [31:0]           seed_q;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  en;
	logic [HASH_W-1:0]     ix, iy, iz;
	item_t                 entry_s1;
	item_t                 item_c   [NUM_CELLS+1];
	logic [D2_W-1:0]       best_c   [NUM_CELLS+1];
	logic [D2_W-1:0]       v_c      [SQRT_STEPS+1];
	logic [REM_W-1:0]      rem_c    [SQRT_STEPS+1];
	logic [ROOT_W-1:0]     root_c   [SQRT_STEPS+1];
	logic [DIST_W-1:0]     dist_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_NOISE_SEED) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
		end else if (psel && penable && pwrite && paddr == ADDR_NOISE_SEED) begin
			seed_q <= pwdata;
		end
	end

	assign en       = !vld_q[PIPE_DEPTH-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	assign ix = {{FRAC_BITS{pos_x[31]}}, pos_x[31:FRAC_BITS]};
	assign iy = {{FRAC_BITS{pos_y[31]}}, pos_y[31:FRAC_BITS]};
	assign iz = {{FRAC_BITS{pos_z[31]}}, pos_z[31:FRAC_BITS]};

	always_ff @(posedge clk) begin
		if (en) begin
			entry_s1.n0      <= ix + iy * MUL_Y + iz * MUL_Z + seed_q * MUL_SEED;
			entry_s1.frac[0] <= pos_x[FRAC_BITS-1:0];
			entry_s1.frac[1] <= pos_y[FRAC_BITS-1:0];
			entry_s1.frac[2] <= pos_z[FRAC_BITS-1:0];
		end
	end

	assign item_c[0] = entry_s1;
	assign best_c[0] = D2_MAX;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		wcn_cell u_cell (
			.clk      (clk),
			.en       (en),
			.ox       (2'(k % 3)),
			.oy       (2'((k / 3) % 3)),
			.oz       (2'(k / 9)),
			.item_in  (item_c[k]),
			.item_out (item_c[k+1]),
			.best_in  (best_c[k]),
			.best_out (best_c[k+1])
		);
	end

	assign v_c[0]    = best_c[NUM_CELLS];
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		wcn_sqrt_step u_step (
			.clk      (clk),
			.en       (en),
			.v_in     (v_c[j]),
			.rem_in   (rem_c[j]),
			.root_in  (root_c[j]),
			.v_out    (v_c[j+1]),
			.rem_out  (rem_c[j+1]),
			.root_out (root_c[j+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= (DIST_W'(root_c[SQRT_STEPS]) > SAT_LIMIT) ? SAT_LIMIT
				: DIST_W'(root_c[SQRT_STEPS]);
		end
	end

	assign out_valid        = vld_q[PIPE_DEPTH-1];
	assign nearest_distance = dist_q;

endmodule
`default_nettype wire

// ===== design/wcn_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcn_checker
// Port-level checks for the Worley noise block, bound to the top level.
// ----------------------------------------------------------------------------
module wcn_checker import wcn_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               pready,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [DIST_W-1:0]  nearest_distance
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(nearest_distance))
		else $error("result dropped or changed while stalled");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nearest_distance <= SAT_LIMIT)
		else $error("distance above saturation limit");

	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind worley_cell_noise_3d wcn_checker u_wcn_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.pready           (pready),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.nearest_distance (nearest_distance)
);
`default_nettype wire
